// ===== hdl/blt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package blt_pkg;

	// Deepest nesting that a brace or bracket count may reach.
	localparam int MaxNest = 255;
	// Stored count width: signed, magnitude up to MaxNest.
	localparam int CntW = $clog2(MaxNest + 1) + 1;

	// Characters that the tokenizer recognizes.
	localparam logic [7:0] ChLBrace   = 8'h7B;
	localparam logic [7:0] ChRBrace   = 8'h7D;
	localparam logic [7:0] ChLBracket = 8'h5B;
	localparam logic [7:0] ChRBracket = 8'h5D;
	localparam logic [7:0] ChSpace    = 8'h20;
	localparam logic [7:0] ChTab      = 8'h09;
	localparam logic [7:0] ChCr       = 8'h0D;
	localparam logic [7:0] ChLf       = 8'h0A;

	// Limits for a count after one step, one bit wider than the stored count.
	localparam logic signed [CntW:0] NestHi = (CntW + 1)'(MaxNest);
	localparam logic signed [CntW:0] NestLo = (CntW + 1)'(-MaxNest);

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_BRACE,
		MODE_BRACKET
	} mode_t;

	// Tokenizer state carried from byte to byte.
	typedef struct packed {
		mode_t                  mode;
		logic signed [CntW-1:0] brace_cnt;
		logic signed [CntW-1:0] bracket_cnt;
		logic                   err;
	} tok_state_t;

	// One result request.
	typedef struct packed {
		logic       valid;
		logic       has_byte;
		logic [7:0] token_byte;
		logic       token_end;
		logic       list_end;
		logic       error;
	} tok_result_t;

	// True when a count has gone past the nesting limit.
	function automatic logic too_deep(input logic signed [CntW:0] v);
		too_deep = (v > NestHi) || (v < NestLo);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/blt_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blt_step
	import blt_pkg::*;
(
	input  wire logic [7:0]  ch,
	input  wire logic        is_last,
	input  wire tok_state_t  cur,
	output tok_state_t       nxt,
	output tok_result_t      res
);

	logic                   is_sp;
	logic                   is_lb;
	logic                   is_rb;
	logic                   is_lk;
	logic                   is_rk;
	logic signed [CntW:0]   brace_ext;
	logic signed [CntW:0]   bracket_ext;
	logic signed [CntW:0]   brace_inc;
	logic signed [CntW:0]   brace_dec;
	logic signed [CntW:0]   bk_brace;
	logic signed [CntW:0]   bk_bracket;
	logic                   bk_deep;
	tok_state_t             mid;
	logic                   emit;
	logic                   has;
	logic                   tend;
	logic                   bad;

	// Character classes of the incoming byte.
	assign is_sp = (ch == ChSpace) || (ch == ChTab) || (ch == ChCr) || (ch == ChLf);
	assign is_lb = (ch == ChLBrace);
	assign is_rb = (ch == ChRBrace);
	assign is_lk = (ch == ChLBracket);
	assign is_rk = (ch == ChRBracket);

	// Count arithmetic, one bit wider so that an overflow shows.
	always_comb begin
		brace_ext   = (CntW + 1)'(cur.brace_cnt);
		bracket_ext = (CntW + 1)'(cur.bracket_cnt);
		brace_inc   = brace_ext + (CntW + 1)'(1);
		brace_dec   = brace_ext - (CntW + 1)'(1);
		bk_brace    = is_lb ? brace_inc : (is_rb ? brace_dec : brace_ext);
		if (is_lk) begin
			bk_bracket = bracket_ext + (CntW + 1)'(1);
		end else if (is_rk) begin
			bk_bracket = bracket_ext - (CntW + 1)'(1);
		end else begin
			bk_bracket = bracket_ext;
		end
		bk_deep = too_deep(bk_brace) || too_deep(bk_bracket);
	end

	// Next state: the byte's effect, then a return to reset after the last byte.
	always_comb begin
		mid = cur;
		if (!cur.err) begin
			unique case (cur.mode)
				MODE_IDLE: begin
					if (is_sp) begin
						mid.mode = MODE_IDLE;
					end else if (is_lb) begin
						mid.mode      = MODE_BRACE;
						mid.brace_cnt = CntW'(1);
					end else if (is_lk) begin
						mid.mode        = MODE_BRACKET;
						mid.bracket_cnt = CntW'(1);
						mid.brace_cnt   = '0;
					end else begin
						mid.mode = MODE_WORD;
					end
				end
				MODE_WORD: begin
					if (is_sp) begin
						mid.mode = MODE_IDLE;
					end
				end
				MODE_BRACE: begin
					if (is_lb) begin
						mid.brace_cnt = brace_inc[CntW-1:0];
						mid.err       = too_deep(brace_inc);
					end else if (is_rb) begin
						mid.brace_cnt = brace_dec[CntW-1:0];
						if (brace_dec == '0) begin
							mid.mode = MODE_IDLE;
						end
					end
				end
				MODE_BRACKET: begin
					mid.brace_cnt   = bk_brace[CntW-1:0];
					mid.bracket_cnt = bk_bracket[CntW-1:0];
					if (bk_deep) begin
						mid.err = 1'b1;
					end else if (is_rk && (bk_bracket == '0) && (bk_brace == '0)) begin
						mid.mode = MODE_IDLE;
					end
				end
				default: mid = cur;
			endcase
		end

		if (is_last) begin
			nxt.mode        = MODE_IDLE;
			nxt.brace_cnt   = '0;
			nxt.bracket_cnt = '0;
			nxt.err         = 1'b0;
		end else begin
			nxt = mid;
		end
	end

	// Result request for this byte.
	always_comb begin
		emit = 1'b0;
		has  = 1'b0;
		tend = 1'b0;
		if (!cur.err) begin
			unique case (cur.mode)
				MODE_IDLE: begin
					if (!is_sp && !is_lb) begin
						emit = 1'b1;
						has  = 1'b1;
					end
				end
				MODE_WORD: begin
					emit = 1'b1;
					has  = !is_sp;
					tend = is_sp;
				end
				MODE_BRACE: begin
					if (is_lb) begin
						emit = !too_deep(brace_inc);
						has  = !too_deep(brace_inc);
					end else if (is_rb && (brace_dec == '0)) begin
						emit = 1'b1;
						tend = 1'b1;
					end else begin
						emit = 1'b1;
						has  = 1'b1;
					end
				end
				MODE_BRACKET: begin
					if (!bk_deep) begin
						emit = 1'b1;
						has  = 1'b1;
						tend = is_rk && (bk_bracket == '0) && (bk_brace == '0);
					end
				end
				default: emit = 1'b0;
			endcase
		end

		bad = mid.err || (mid.mode == MODE_BRACE) || (mid.mode == MODE_BRACKET);

		if (is_last) begin
			res.valid      = 1'b1;
			res.list_end   = 1'b1;
			res.error      = bad;
			res.has_byte   = !bad && has;
			res.token_byte = (!bad && has) ? ch : 8'h00;
			res.token_end  = !bad && (tend || (mid.mode == MODE_WORD));
		end else begin
			res.valid      = emit;
			res.list_end   = 1'b0;
			res.error      = 1'b0;
			res.has_byte   = has;
			res.token_byte = has ? ch : 8'h00;
			res.token_end  = tend;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/brace_list_tokenizer.sv =====
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  ch, is_last
// result    out        out_valid/out_stall  has_byte, token_byte, token_end, list_end, error
//
// One byte is taken every cycle while in_stall is low; its result passes through the input
// register, then the result register, set by the single state update per byte.
// Bytes that give no result advance even while the result register is stalled.
// Reset puts the tokenizer between tokens with both counts at zero; no clearing pass.
// A stalled result holds its value; the input stalls only when its byte must wait for it.
`timescale 1ns / 1ps
`default_nettype none

module brace_list_tokenizer
	import blt_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] ch,
	input  wire logic       is_last,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            has_byte,
	output logic [7:0]      token_byte,
	output logic            token_end,
	output logic            list_end,
	output logic            error
);

	logic        in_vld_s1;
	logic [7:0]  ch_s1;
	logic        last_s1;
	tok_state_t  state_q;
	tok_state_t  state_nxt;
	tok_result_t res;
	tok_result_t res_q;
	logic        out_vld_q;
	logic        adv;

	// Per-byte tokenizer logic.
	blt_step u_step (
		.ch      (ch_s1),
		.is_last (last_s1),
		.cur     (state_q),
		.nxt     (state_nxt),
		.res     (res)
	);

	// The held byte moves on when it has no result or the result register is free.
	assign adv      = in_vld_s1 && (!res.valid || !out_vld_q || !out_stall);
	assign in_stall = in_vld_s1 && !adv;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_vld_s1 <= 1'b0;
		end else if (!in_stall) begin
			in_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			ch_s1   <= ch;
			last_s1 <= is_last;
		end
	end

	// Tokenizer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.mode        <= MODE_IDLE;
			state_q.brace_cnt   <= '0;
			state_q.bracket_cnt <= '0;
			state_q.err         <= 1'b0;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else begin
			out_vld_q <= (out_vld_q && out_stall) || (adv && res.valid);
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res.valid) begin
			res_q <= res;
		end
	end

	assign out_valid  = out_vld_q;
	assign has_byte   = res_q.has_byte;
	assign token_byte = res_q.token_byte;
	assign token_end  = res_q.token_end;
	assign list_end   = res_q.list_end;
	assign error      = res_q.error;

endmodule

`default_nettype wire

// ===== hdl/blt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module blt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] ch,
	input wire logic       is_last,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       has_byte,
	input wire logic [7:0] token_byte,
	input wire logic       token_end,
	input wire logic       list_end,
	input wire logic       error
);

	// An error is only reported at the end of the string.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> list_end)
		else $error("error without list_end");

	// A void list carries no token byte and no token end.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error |-> !has_byte && !token_end)
		else $error("error request carries token data");

	// Without a byte the byte field reads zero.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> token_byte == 8'h00)
		else $error("token_byte nonzero without has_byte");

	// A request that carries neither byte nor token end must end the list.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte && !token_end |-> list_end)
		else $error("empty request outside list end");

	// A stalled request holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(token_byte) && $stable(list_end))
		else $error("stalled request changed");

endmodule

bind brace_list_tokenizer blt_checker u_blt_checker (.*);

`default_nettype wire

// ===== bench/tb_brace_list_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_brace_list_tokenizer;
	import blt_pkg::*;

	// Cycles with no request moving on either channel before the run is called hung.
	localparam int QuietLimit = 2000;
	// Results to collect in each random phase.
	localparam int ResultsPerPhase = 140;

	// One result request as the bench expects it.
	typedef struct packed {
		logic       has_byte;
		logic [7:0] token_byte;
		logic       token_end;
		logic       list_end;
		logic       error;
	} token_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] ch = 8'h00;
	logic       is_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       has_byte;
	logic [7:0] token_byte;
	logic       token_end;
	logic       list_end;
	logic       error;

	// Tokenizer state as the bench tracks it.
	mode_t tok_mode = MODE_IDLE;
	int    brace_depth = 0;
	int    bracket_depth = 0;
	bit    nest_overflow = 1'b0;

	token_beat_t token_beats_due[$];
	logic [7:0]  text_buf[$];
	int          failures = 0;
	int          quiet_cycles = 0;
	int          results_made = 0;
	int          idle_pct = 0;
	int          stall_pct = 0;

	brace_list_tokenizer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.ch        (ch),
		.is_last   (is_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.has_byte  (has_byte),
		.token_byte(token_byte),
		.token_end (token_end),
		.list_end  (list_end),
		.error     (error)
	);

	// Free-running clock with a 4 ns period.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The receiver stalls at random, at the rate of the current phase.
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic bit is_ws(input logic [7:0] c);
		return c == ChSpace || c == ChTab || c == ChCr || c == ChLf;
	endfunction

	function automatic bit beyond_nest(input int depth);
		return depth > MaxNest || depth < -MaxNest;
	endfunction

	function automatic void clear_tokenizer();
		tok_mode = MODE_IDLE;
		brace_depth = 0;
		bracket_depth = 0;
		nest_overflow = 1'b0;
	endfunction

	// Advance the tracked state by one byte and queue the result it causes.
	// Returns 1 when the byte produces a result.
	function automatic bit tokenize_char(input logic [7:0] c, input logic last);
		bit          emit;
		bit          has;
		bit          tend;
		bit          bad;
		token_beat_t beat;
		emit = 1'b0;
		has = 1'b0;
		tend = 1'b0;
		if (!nest_overflow) begin
			case (tok_mode)
				MODE_IDLE: begin
					if (c == ChLBrace) begin
						tok_mode = MODE_BRACE;
						brace_depth = 1;
					end else if (c == ChLBracket) begin
						tok_mode = MODE_BRACKET;
						bracket_depth = 1;
						brace_depth = 0;
						emit = 1'b1;
						has = 1'b1;
					end else if (!is_ws(c)) begin
						tok_mode = MODE_WORD;
						emit = 1'b1;
						has = 1'b1;
					end
				end
				MODE_WORD: begin
					emit = 1'b1;
					if (is_ws(c)) begin
						tend = 1'b1;
						tok_mode = MODE_IDLE;
					end else begin
						has = 1'b1;
					end
				end
				MODE_BRACE: begin
					if (c == ChLBrace) begin
						brace_depth++;
						if (beyond_nest(brace_depth)) begin
							nest_overflow = 1'b1;
						end else begin
							emit = 1'b1;
							has = 1'b1;
						end
					end else if (c == ChRBrace) begin
						brace_depth--;
						emit = 1'b1;
						if (brace_depth == 0) begin
							tend = 1'b1;
							tok_mode = MODE_IDLE;
						end else begin
							has = 1'b1;
						end
					end else begin
						emit = 1'b1;
						has = 1'b1;
					end
				end
				default: begin
					// Inside a bracket token both counts move and the token keeps every byte.
					if (c == ChLBrace) brace_depth++;
					else if (c == ChRBrace) brace_depth--;
					else if (c == ChLBracket) bracket_depth++;
					else if (c == ChRBracket) bracket_depth--;
					if (beyond_nest(brace_depth) || beyond_nest(bracket_depth)) begin
						nest_overflow = 1'b1;
					end else begin
						emit = 1'b1;
						has = 1'b1;
						if (c == ChRBracket && bracket_depth == 0 && brace_depth == 0) begin
							tend = 1'b1;
							tok_mode = MODE_IDLE;
						end
					end
				end
			endcase
		end

		// The last byte always reports the end of the list, void if anything is left open.
		if (last) begin
			bad = nest_overflow || tok_mode == MODE_BRACE || tok_mode == MODE_BRACKET;
			beat = '0;
			beat.list_end = 1'b1;
			beat.error = bad;
			if (!bad) begin
				beat.has_byte = has;
				beat.token_byte = has ? c : 8'h00;
				beat.token_end = tend || tok_mode == MODE_WORD;
			end
			clear_tokenizer();
			token_beats_due.push_back(beat);
			return 1'b1;
		end
		if (!emit) return 1'b0;
		beat = '0;
		beat.has_byte = has;
		beat.token_byte = has ? c : 8'h00;
		beat.token_end = tend;
		token_beats_due.push_back(beat);
		return 1'b1;
	endfunction

	task automatic compare_field(input string field, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
			failures++;
		end
	endtask

	// Every accepted result request is checked against the oldest expectation.
	always @(posedge clk) begin : check_results
		token_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (token_beats_due.size() == 0) begin
				$display("%0t: unexpected result: expected none, actual has_byte=%0b byte=%02h %s%0b",
					$time, has_byte, token_byte, "token_end/list_end/error=",
					{token_end, list_end, error});
				failures++;
			end else begin
				want = token_beats_due.pop_front();
				compare_field("has_byte", want.has_byte, has_byte);
				compare_field("token_byte", want.token_byte, token_byte);
				compare_field("token_end", want.token_end, token_end);
				compare_field("list_end", want.list_end, list_end);
				compare_field("error", want.error, error);
			end
		end
	end

	// End the run when nothing has moved for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
			else quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QuietLimit) begin
				$display("%0t: no progress for %0d cycles", $time, quiet_cycles);
				$display("brace_list_tokenizer regression: fail");
				$finish;
			end
		end
	end

	// Offer one byte, with random idle cycles ahead of it, and wait until it is taken.
	task automatic feed_char(input logic [7:0] c, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		ch <= c;
		is_last <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (tokenize_char(c, last)) results_made++;
	endtask

	// Send the built string, marking its final byte, and clear the buffer.
	task automatic feed_text();
		for (int i = 0; i < text_buf.size(); i++) begin
			feed_char(text_buf[i], i == text_buf.size() - 1);
		end
		text_buf.delete();
	endtask

	// Hold the sender off until every expected result has been taken.
	task automatic pause_until_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (token_beats_due.size() != 0) @(posedge clk);
	endtask

	task automatic add_text(input string s);
		for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
	endtask

	task automatic add_repeat(input logic [7:0] c, input int n);
		repeat (n) text_buf.push_back(c);
	endtask

	function automatic logic [7:0] space_char();
		case ($urandom_range(3))
			0: return ChSpace;
			1: return ChTab;
			2: return ChCr;
			default: return ChLf;
		endcase
	endfunction

	// Random byte, optionally kept clear of whitespace, braces or brackets.
	function automatic logic [7:0] random_char(input bit no_space, input bit no_brace,
			input bit no_bracket);
		logic [7:0] c;
		c = 8'($urandom_range(255));
		while ((no_space && is_ws(c)) ||
				(no_brace && (c == ChLBrace || c == ChRBrace)) ||
				(no_bracket && (c == ChLBracket || c == ChRBracket)))
			c = 8'($urandom_range(255));
		return c;
	endfunction

	function automatic logic [7:0] special_char();
		case ($urandom_range(5))
			0: return ChLBrace;
			1: return ChRBrace;
			2: return ChLBracket;
			3: return ChRBracket;
			4: return space_char();
			default: return random_char(1'b1, 1'b1, 1'b1);
		endcase
	endfunction

	task automatic add_word();
		text_buf.push_back(random_char(1'b1, 1'b1, 1'b1));
		repeat ($urandom_range(0, 6)) text_buf.push_back(random_char(1'b1, 1'b0, 1'b0));
	endtask

	// Balanced brace token; brackets may appear in it unless it sits in a bracket token.
	task automatic add_brace_token(input int depth, input bit with_brackets);
		text_buf.push_back(ChLBrace);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(5))
				0: begin
					if (depth < 3) add_brace_token(depth + 1, with_brackets);
					else text_buf.push_back(random_char(1'b1, 1'b1, 1'b1));
				end
				1: text_buf.push_back(space_char());
				2: begin
					if (with_brackets) text_buf.push_back($urandom_range(1) ? ChLBracket : ChRBracket);
					else text_buf.push_back(random_char(1'b1, 1'b1, 1'b1));
				end
				default: text_buf.push_back(random_char(1'b0, 1'b1, !with_brackets));
			endcase
		end
		text_buf.push_back(ChRBrace);
	endtask

	// Balanced bracket token with nested brackets and brace groups.
	task automatic add_bracket_token(input int depth);
		text_buf.push_back(ChLBracket);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(5))
				0: begin
					if (depth < 3) add_bracket_token(depth + 1);
					else text_buf.push_back(random_char(1'b1, 1'b1, 1'b1));
				end
				1: add_brace_token(depth, 1'b0);
				2: text_buf.push_back(space_char());
				default: text_buf.push_back(random_char(1'b0, 1'b1, 1'b1));
			endcase
		end
		text_buf.push_back(ChRBracket);
	endtask

	// Mostly well-formed lists, some cut short, some plain noise.
	task automatic build_random_string();
		int shape;
		int pieces;
		int keep;
		bit after_word;
		text_buf.delete();
		shape = $urandom_range(99);
		after_word = 1'b0;
		if (shape < 10) begin
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(1)) text_buf.push_back(random_char(1'b0, 1'b0, 1'b0));
				else text_buf.push_back(special_char());
			end
		end else begin
			pieces = $urandom_range(1, 5);
			repeat ($urandom_range(0, 1)) text_buf.push_back(space_char());
			for (int i = 0; i < pieces; i++) begin
				// A word needs whitespace after it; other tokens may be packed tight.
				if (i > 0 && (after_word || $urandom_range(1)))
					repeat ($urandom_range(1, 2)) text_buf.push_back(space_char());
				case ($urandom_range(2))
					0: begin
						add_word();
						after_word = 1'b1;
					end
					1: begin
						add_brace_token(0, 1'b1);
						after_word = 1'b0;
					end
					default: begin
						add_bracket_token(0);
						after_word = 1'b0;
					end
				endcase
			end
			repeat ($urandom_range(0, 2)) text_buf.push_back(space_char());
			// Some strings are cut short so that tokens stay open at the end.
			if (shape < 25) begin
				keep = $urandom_range(1, text_buf.size());
				while (text_buf.size() > keep) void'(text_buf.pop_back());
			end
		end
	endtask

	// Plain words, every whitespace kind, byte extremes, and whitespace as the last byte.
	task automatic test_plain_words();
		add_text("a\tb\r\n}]");
		feed_text();
		text_buf.push_back(8'h00);
		text_buf.push_back(8'hFF);
		text_buf.push_back(ChSpace);
		feed_text();
	endtask

	// Empty and non-empty brace tokens, packed against the next token.
	task automatic test_brace_tokens();
		add_text("{}{a b}x");
		feed_text();
	endtask

	// Bracket tokens with counts that touch zero or go negative before closing.
	task automatic test_bracket_tokens();
		add_text("[{]]}[[]");
		feed_text();
		add_text("[}{]");
		feed_text();
	endtask

	// Brace and bracket tokens left open at the end of the string.
	task automatic test_unclosed_tokens();
		add_text("{a");
		feed_text();
		add_text("[");
		feed_text();
	endtask

	// Counts at the nesting limit and one step past it, in both directions.
	task automatic test_nesting_limit();
		idle_pct = 38;
		stall_pct = 38;
		add_repeat(ChLBrace, MaxNest + 1);
		add_text("ab}");
		feed_text();
		add_repeat(ChLBracket, MaxNest + 1);
		add_repeat(ChRBracket, 2);
		feed_text();
		// A brace keeps the bracket token open while its count goes negative.
		text_buf.push_back(ChLBracket);
		text_buf.push_back(ChLBrace);
		add_repeat(ChRBracket, MaxNest + 2);
		add_text("x");
		feed_text();
		text_buf.push_back(ChLBracket);
		add_repeat(ChRBrace, MaxNest + 1);
		add_text(" ");
		feed_text();
		pause_until_drained();
	endtask

	// Random strings until the phase has produced its share of results.
	task automatic test_random(input int sender_idle, input int receiver_stall);
		int start;
		idle_pct = sender_idle;
		stall_pct = receiver_stall;
		start = results_made;
		while (results_made - start < ResultsPerPhase) begin
			build_random_string();
			feed_text();
		end
		pause_until_drained();
	endtask

	// Reset once, run each test in turn, then give the verdict.
	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_plain_words();
		test_brace_tokens();
		test_bracket_tokens();
		test_unclosed_tokens();
		test_nesting_limit();
		test_random(0, 0);
		test_random(64, 0);
		test_random(0, 64);
		test_random(38, 38);
		pause_until_drained();
		// Leave room for any stray result to show up.
		repeat (10) @(posedge clk);
		if (failures == 0) begin
			$display("brace_list_tokenizer regression: pass");
		end else begin
			$display("brace_list_tokenizer regression: fail");
		end
		$finish;
	end

endmodule
